### hdl/kps_pkg.sv
// Shared types, constants and lookup functions for the 3x4 keypad scanner.
// No dependencies; every other file in hdl/ imports this package.
package kps_pkg;

  localparam int ColW      = 4;
  localparam int RowW      = 3;
  localparam int KeyW      = 4;
  localparam int SettleW   = 16;
  localparam int DebounceW = 20;
  localparam int WaitW     = 20;
  localparam int CfgW      = 20;
  localparam int CfgIdxW   = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SETTLE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd1;

  localparam logic [SettleW-1:0]   SETTLE_RESET   = 16'd200;
  localparam logic [DebounceW-1:0] DEBOUNCE_RESET = 20'd100000;

  // Special key codes on row 2
  localparam logic [KeyW-1:0] KEY_OK     = 4'd11;
  localparam logic [KeyW-1:0] KEY_CANCEL = 4'd12;

  // One result item
  typedef struct packed {
    logic [RowW-1:0] row_drive;
    logic            key_valid;
    logic [KeyW-1:0] key_code;
    logic            no_key_pass;
  } kps_result_t;

  // Lowest column reading low; caller checks that at least one is low
  function automatic logic [1:0] low_column(input logic [ColW-1:0] cols);
    logic [1:0] c;
    c = 2'd3;
    if (!cols[2]) c = 2'd2;
    if (!cols[1]) c = 2'd1;
    if (!cols[0]) c = 2'd0;
    return c;
  endfunction

  // Key code for a row and column
  function automatic logic [KeyW-1:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [KeyW-1:0] k;
    case (row)
      2'd0: k = {2'b00, col} + 4'd1;
      2'd1: k = {2'b00, col} + 4'd5;
      2'd2: begin
        case (col)
          2'd0:    k = 4'd9;
          2'd1:    k = 4'd0;
          2'd2:    k = KEY_OK;
          default: k = KEY_CANCEL;
        endcase
      end
      default: k = 4'd0;
    endcase
    return k;
  endfunction

endpackage

### hdl/kps_if.sv
// Valid/ready channel interfaces for column samples and scan results.
// Depends on kps_pkg for field widths.
interface kps_col_if import kps_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ColW-1:0] column_lines;

  modport source (output valid, output column_lines, input ready);
  modport sink   (input valid, input column_lines, output ready);
endinterface

interface kps_key_if import kps_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RowW-1:0] row_drive;
  logic            key_valid;
  logic [KeyW-1:0] key_code;
  logic            no_key_pass;

  modport source (output valid, output row_drive, output key_valid, output key_code,
                  output no_key_pass, input ready);
  modport sink   (input valid, input row_drive, input key_valid, input key_code,
                  input no_key_pass, output ready);
endinterface

### hdl/matrix_keypad_scanner_top.sv
// 3x4 matrix keypad scanner, one column sample (timer tick) per input transfer.
// An input transfer is held in the input register, then the scan step forms its
// result into the result register, which drives the output channel.
// Throughput: one tick per cycle while the result channel is not stalled.
// Reset (rst, synchronous): scan at the pre-drive settle of row 0, counters
// cleared, settle_ticks = 200, debounce_ticks = 100000, both channels empty.
module matrix_keypad_scanner_top import kps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  kps_col_if.sink            col_in,
  kps_key_if.source          key_out,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata
);

  logic [SettleW-1:0]   settle_ticks;
  logic [DebounceW-1:0] debounce_ticks;
  logic                 in_valid;
  logic [ColW-1:0]      in_cols;
  logic                 out_free;
  logic                 step;
  kps_result_t          step_result;
  kps_result_t          out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks   <= SETTLE_RESET;
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE:   settle_ticks   <= cfg_wdata[SettleW-1:0];
        CFG_DEBOUNCE: debounce_ticks <= cfg_wdata[DebounceW-1:0];
        default: ;
      endcase
    end
  end

  assign step = in_valid && out_free;

  kps_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (col_in.valid),
    .up_ready   (col_in.ready),
    .up_cols    (col_in.column_lines),
    .take       (step),
    .held_valid (in_valid),
    .held_cols  (in_cols)
  );

  kps_scan_fsm u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .cols           (in_cols),
    .settle_ticks   (settle_ticks),
    .debounce_ticks (debounce_ticks),
    .result         (step_result)
  );

  kps_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .load_data (step_result),
    .free      (out_free),
    .out_valid (key_out.valid),
    .out_ready (key_out.ready),
    .out_data  (out_data)
  );

  assign key_out.row_drive   = out_data.row_drive;
  assign key_out.key_valid   = out_data.key_valid;
  assign key_out.key_code    = out_data.key_code;
  assign key_out.no_key_pass = out_data.no_key_pass;

endmodule

### hdl/kps_in_reg.sv
// Input register for column samples: takes a transfer whenever it is empty
// or its item moves on in the same cycle. Depends on kps_pkg.
module kps_in_reg import kps_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  logic [ColW-1:0] up_cols,
  input  logic            take,
  output logic            held_valid,
  output logic [ColW-1:0] held_cols
);

  assign up_ready = !held_valid || take;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (up_ready) begin
      held_valid <= up_valid;
    end
  end

  // Capture the sample on a transfer
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      held_cols <= up_cols;
    end
  end

endmodule

### hdl/kps_scan_fsm.sv
// Scan sequencer: phase, row, wait counter and held key; advances one tick
// per step and forms the result item. Depends on kps_pkg.
module kps_scan_fsm import kps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [ColW-1:0]      cols,
  input  logic [SettleW-1:0]   settle_ticks,
  input  logic [DebounceW-1:0] debounce_ticks,
  output kps_result_t          result
);

  localparam logic [2:0] PH_PRE      = 3'd0;
  localparam logic [2:0] PH_DRIVEN   = 3'd1;
  localparam logic [2:0] PH_HOLD     = 3'd2;
  localparam logic [2:0] PH_DEBOUNCE = 3'd3;
  localparam logic [2:0] PH_RELEASE  = 3'd4;

  logic [2:0]       phase, phase_next, eff_phase;
  logic [1:0]       row, row_next;
  logic [WaitW-1:0] wait_cnt, wait_next, wait_inc;
  logic [ColW-1:0]  held_columns, held_columns_next;
  logic [KeyW-1:0]  held_key, held_key_next;
  logic             settle_hit, debounce_hit;

  assign wait_inc     = wait_cnt + 20'd1;
  assign settle_hit   = wait_cnt >= {4'b0, settle_ticks};
  assign debounce_hit = wait_cnt >= debounce_ticks;

  // Next state for one tick
  always_comb begin
    eff_phase         = (row > 2'd2) ? PH_PRE : phase;
    row_next          = (row > 2'd2) ? 2'd0 : row;
    phase_next        = eff_phase;
    wait_next         = wait_cnt;
    held_columns_next = held_columns;
    held_key_next     = held_key;
    result            = '0;
    case (eff_phase)
      PH_DRIVEN: begin
        if (settle_hit) begin
          wait_next         = '0;
          held_columns_next = cols;
          if (cols != 4'hF) begin
            held_key_next = key_lookup(row_next, low_column(cols));
            phase_next    = PH_HOLD;
          end else begin
            phase_next = PH_RELEASE;
          end
        end else begin
          wait_next = wait_inc;
        end
      end
      PH_HOLD: begin
        if (cols != held_columns) begin
          wait_next  = '0;
          phase_next = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (debounce_hit) begin
          wait_next        = '0;
          result.key_valid = 1'b1;
          result.key_code  = held_key;
          row_next         = 2'd0;
          phase_next       = PH_PRE;
        end else begin
          wait_next = wait_inc;
        end
      end
      PH_RELEASE: begin
        if (settle_hit) begin
          wait_next = '0;
          if (row_next >= 2'd2) begin
            result.no_key_pass = 1'b1;
            row_next           = 2'd0;
            phase_next         = PH_PRE;
          end else begin
            row_next   = row_next + 2'd1;
            phase_next = PH_DRIVEN;
          end
        end else begin
          wait_next = wait_inc;
        end
      end
      PH_PRE: begin
        if (settle_hit) begin
          wait_next  = '0;
          phase_next = PH_DRIVEN;
        end else begin
          wait_next = wait_inc;
        end
      end
      default: begin
        wait_next  = '0;
        row_next   = 2'd0;
        phase_next = PH_PRE;
      end
    endcase
    // Drive the row low while it is being read
    if (phase_next == PH_DRIVEN || phase_next == PH_HOLD || phase_next == PH_DEBOUNCE) begin
      result.row_drive = ~(3'b001 << row_next);
    end else begin
      result.row_drive = 3'b111;
    end
  end

  // Advance the scan state on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PRE;
      row          <= 2'd0;
      wait_cnt     <= '0;
      held_columns <= 4'hF;
      held_key     <= '0;
    end else if (step) begin
      phase        <= phase_next;
      row          <= row_next;
      wait_cnt     <= wait_next;
      held_columns <= held_columns_next;
      held_key     <= held_key_next;
    end
  end

endmodule

### hdl/kps_out_reg.sv
// Result register: loads a result when empty or drained in the same cycle,
// and holds it under backpressure. Depends on kps_pkg.
module kps_out_reg import kps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  kps_result_t load_data,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output kps_result_t out_data
);

  assign free = !out_valid || out_ready;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (load && free) begin
      out_data <= load_data;
    end
  end

endmodule

### hdl/kps_checker.sv
// Port-level checks on the scanner result channel, bound to the top level.
// Depends on kps_pkg and matrix_keypad_scanner_top.
module kps_checker import kps_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input logic [RowW-1:0] row_drive,
  input logic            key_valid,
  input logic [KeyW-1:0] key_code,
  input logic            no_key_pass
);

  // A key report and a no-key pulse never share a result
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(key_valid && no_key_pass))
    else $error("key report and no-key pulse in one result");

  // Reports come with every row released
  a_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && (key_valid || no_key_pass) |-> row_drive == 3'b111)
    else $error("row still driven on a report");

  // Key code is zero without a report, and a legal code with one
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_valid ? (key_code <= KEY_CANCEL && key_code != 4'd10)
                             : key_code == 4'd0))
    else $error("bad key code");

  // At most one row is driven at a time
  a_one_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones(~row_drive) <= 1)
    else $error("more than one row driven");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_drive) && $stable(key_valid)
                               && $stable(key_code) && $stable(no_key_pass))
    else $error("stalled result changed");

endmodule

bind matrix_keypad_scanner_top kps_checker u_kps_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (key_out.valid),
  .out_ready   (key_out.ready),
  .row_drive   (key_out.row_drive),
  .key_valid   (key_out.key_valid),
  .key_code    (key_out.key_code),
  .no_key_pass (key_out.no_key_pass)
);
